/* hw/rtl/dsa_pkg.sv */
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared widths, state type and controller/datapath command and status types
// for the decimal scale alignment block.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int WORD_W      = 32;
   localparam int MANT_LOW_W  = 64;
   localparam int MANT_HIGH_W = 32;
   localparam int FULL_W      = 96;
   localparam int SCALE_W     = 8;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } dsa_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } dsa_cmd_type;

   typedef struct packed {
      logic done;
      logic rsp_busy;
   } dsa_status_type;

endpackage

/* hw/rtl/dsa_req_if.sv */
// ----------------------------------------------------------------------------
// dsa_req_if
// Input channel: one operand pair per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsa_req_if;

   logic                             valid;
   logic                             ready;
   logic [dsa_pkg::MANT_LOW_W-1:0]   a_mant_low;
   logic [dsa_pkg::MANT_HIGH_W-1:0]  a_mant_high;
   logic [dsa_pkg::SCALE_W-1:0]      a_scale;
   logic [dsa_pkg::MANT_LOW_W-1:0]   b_mant_low;
   logic [dsa_pkg::MANT_HIGH_W-1:0]  b_mant_high;
   logic [dsa_pkg::SCALE_W-1:0]      b_scale;

   modport source (
      output valid, a_mant_low, a_mant_high, a_scale, b_mant_low, b_mant_high, b_scale,
      input  ready
   );

   modport sink (
      input  valid, a_mant_low, a_mant_high, a_scale, b_mant_low, b_mant_high, b_scale,
      output ready
   );

endinterface

/* hw/rtl/dsa_rsp_if.sv */
// ----------------------------------------------------------------------------
// dsa_rsp_if
// Result channel: one aligned operand pair per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsa_rsp_if;

   logic                             valid;
   logic                             ready;
   logic [dsa_pkg::MANT_LOW_W-1:0]   a_out_low;
   logic [dsa_pkg::MANT_HIGH_W-1:0]  a_out_high;
   logic [dsa_pkg::SCALE_W-1:0]      a_out_scale;
   logic [dsa_pkg::MANT_LOW_W-1:0]   b_out_low;
   logic [dsa_pkg::MANT_HIGH_W-1:0]  b_out_high;
   logic [dsa_pkg::SCALE_W-1:0]      b_out_scale;
   logic                             overflow;

   modport source (
      output valid, a_out_low, a_out_high, a_out_scale, b_out_low, b_out_high,
             b_out_scale, overflow,
      input  ready
   );

   modport sink (
      input  valid, a_out_low, a_out_high, a_out_scale, b_out_low, b_out_high,
             b_out_scale, overflow,
      output ready
   );

endinterface

/* hw/rtl/dsa_ctrl.sv */
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer: accepts an item, steps the datapath until it reports done, then
// moves the aligned pair into the result register once that register is free.
// ----------------------------------------------------------------------------
module dsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dsa_pkg::dsa_status_type status,
   output dsa_pkg::dsa_cmd_type    cmd
);

   dsa_pkg::dsa_state_type state_ff;
   dsa_pkg::dsa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         dsa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = dsa_pkg::ST_RUN;
            end
         end
         dsa_pkg::ST_RUN: begin
            if (!status.done) begin
               cmd.step = 1'b1;
            end else if (!status.rsp_busy) begin
               cmd.publish = 1'b1;
               state_in    = dsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/dsa_datapath.sv */
// ----------------------------------------------------------------------------
// dsa_datapath
// Working mantissas and scales, one times-ten step per cycle on the operand
// with the smaller scale, overflow flag and the result register.
// ----------------------------------------------------------------------------
module dsa_datapath #(
   parameter int MANT_WORDS = 3,
   parameter int MAX_SCALE  = 28
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dsa_pkg::dsa_cmd_type              cmd,
   output dsa_pkg::dsa_status_type           status,
   input  logic [dsa_pkg::MANT_LOW_W-1:0]    a_mant_low,
   input  logic [dsa_pkg::MANT_HIGH_W-1:0]   a_mant_high,
   input  logic [dsa_pkg::SCALE_W-1:0]       a_scale,
   input  logic [dsa_pkg::MANT_LOW_W-1:0]    b_mant_low,
   input  logic [dsa_pkg::MANT_HIGH_W-1:0]   b_mant_high,
   input  logic [dsa_pkg::SCALE_W-1:0]       b_scale,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [dsa_pkg::MANT_LOW_W-1:0]    a_out_low,
   output logic [dsa_pkg::MANT_HIGH_W-1:0]   a_out_high,
   output logic [dsa_pkg::SCALE_W-1:0]       a_out_scale,
   output logic [dsa_pkg::MANT_LOW_W-1:0]    b_out_low,
   output logic [dsa_pkg::MANT_HIGH_W-1:0]   b_out_high,
   output logic [dsa_pkg::SCALE_W-1:0]       b_out_scale,
   output logic                              overflow
);

   localparam int MANT_W = MANT_WORDS * dsa_pkg::WORD_W;
   localparam int PROD_W = MANT_W + 4;
   localparam int FULL_W = dsa_pkg::FULL_W;
   localparam int SW     = dsa_pkg::SCALE_W;

   logic [FULL_W-1:0] a_full;
   logic [FULL_W-1:0] b_full;

   logic [MANT_W-1:0] a_mant_ff, a_mant_in;
   logic [MANT_W-1:0] b_mant_ff, b_mant_in;
   logic [SW-1:0]     a_scale_ff, a_scale_in;
   logic [SW-1:0]     b_scale_ff, b_scale_in;
   logic              ovf_ff, ovf_in;
   logic              raise_a_ff, raise_a_in;

   logic [FULL_W-1:0] res_a_ff, res_a_in;
   logic [FULL_W-1:0] res_b_ff, res_b_in;
   logic [SW-1:0]     res_a_scale_ff, res_a_scale_in;
   logic [SW-1:0]     res_b_scale_ff, res_b_scale_in;
   logic              res_ovf_ff, res_ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [MANT_W-1:0] lo_mant;
   logic [SW-1:0]     lo_scale;
   logic [SW-1:0]     hi_scale;
   logic [PROD_W-1:0] prod_ext;
   logic [PROD_W-1:0] prod;
   logic              carry;
   logic [MANT_W-1:0] step_mant;
   logic [SW-1:0]     step_scale;
   logic              done;

   assign a_full = {a_mant_high, a_mant_low};
   assign b_full = {b_mant_high, b_mant_low};

   assign lo_mant    = raise_a_ff ? a_mant_ff  : b_mant_ff;
   assign lo_scale   = raise_a_ff ? a_scale_ff : b_scale_ff;
   assign hi_scale   = raise_a_ff ? b_scale_ff : a_scale_ff;
   assign prod_ext   = PROD_W'(lo_mant);
   assign prod       = (prod_ext << 3) + (prod_ext << 1);
   assign carry      = |prod[PROD_W-1:MANT_W];
   assign step_mant  = prod[MANT_W-1:0];
   assign step_scale = carry ? lo_scale : SW'(lo_scale + 1'b1);
   assign done       = ovf_ff || (lo_scale >= hi_scale) || (lo_scale >= SW'(MAX_SCALE));

   assign status = '{done: done, rsp_busy: rsp_valid_ff && !rsp_ready};

   always_comb begin
      a_mant_in  = a_mant_ff;
      b_mant_in  = b_mant_ff;
      a_scale_in = a_scale_ff;
      b_scale_in = b_scale_ff;
      ovf_in     = ovf_ff;
      raise_a_in = raise_a_ff;
      if (cmd.load) begin
         a_mant_in  = a_full[MANT_W-1:0];
         b_mant_in  = b_full[MANT_W-1:0];
         a_scale_in = a_scale;
         b_scale_in = b_scale;
         ovf_in     = 1'b0;
         raise_a_in = a_scale < b_scale;
      end else if (cmd.step) begin
         ovf_in = ovf_ff | carry;
         if (raise_a_ff) begin
            a_mant_in  = step_mant;
            a_scale_in = step_scale;
         end else begin
            b_mant_in  = step_mant;
            b_scale_in = step_scale;
         end
      end
   end

   always_comb begin
      res_a_in       = res_a_ff;
      res_b_in       = res_b_ff;
      res_a_scale_in = res_a_scale_ff;
      res_b_scale_in = res_b_scale_ff;
      res_ovf_in     = res_ovf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (cmd.publish) begin
         res_a_in                 = '0;
         res_a_in[MANT_W-1:0]     = a_mant_ff;
         res_b_in                 = '0;
         res_b_in[MANT_W-1:0]     = b_mant_ff;
         res_a_scale_in           = a_scale_ff;
         res_b_scale_in           = b_scale_ff;
         res_ovf_in               = ovf_ff;
         rsp_valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      a_mant_ff      <= a_mant_in;
      b_mant_ff      <= b_mant_in;
      a_scale_ff     <= a_scale_in;
      b_scale_ff     <= b_scale_in;
      ovf_ff         <= ovf_in;
      raise_a_ff     <= raise_a_in;
      res_a_ff       <= res_a_in;
      res_b_ff       <= res_b_in;
      res_a_scale_ff <= res_a_scale_in;
      res_b_scale_ff <= res_b_scale_in;
      res_ovf_ff     <= res_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign a_out_low   = res_a_ff[dsa_pkg::MANT_LOW_W-1:0];
   assign a_out_high  = res_a_ff[FULL_W-1:dsa_pkg::MANT_LOW_W];
   assign a_out_scale = res_a_scale_ff;
   assign b_out_low   = res_b_ff[dsa_pkg::MANT_LOW_W-1:0];
   assign b_out_high  = res_b_ff[FULL_W-1:dsa_pkg::MANT_LOW_W];
   assign b_out_scale = res_b_scale_ff;
   assign overflow    = res_ovf_ff;

   step_only_when_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !done)
      else $error("times-ten step issued after alignment finished");

   step_raises_scale: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !carry) |=>
         ((raise_a_ff ? a_scale_ff : b_scale_ff) == SW'($past(lo_scale) + 1'b1)))
      else $error("scale not raised by one after a clean step");

   overflow_freezes_scale: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && carry) |=> (ovf_ff && $stable(a_scale_ff) && $stable(b_scale_ff)))
      else $error("carry out did not stop alignment");

   publish_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten before it was taken");

endmodule

/* hw/rtl/decimal_scale_align_top.sv */
// ----------------------------------------------------------------------------
// decimal_scale_align_top
// Brings two unsigned 96-bit decimal mantissas to a common decimal scale.
// ----------------------------------------------------------------------------
// An item is accepted while the block is idle, then takes n times-ten steps,
// one per cycle, and then moves into the result register; the next item is
// accepted only once the block is back in idle after that move. Here n is the
// difference of the two scales, capped by MAX_SCALE minus the smaller scale,
// and cut short by an overflow. The steps are made by the single times-ten
// adder, which performs one step per cycle on the operand with the smaller
// scale. The result register frees the block to take the next item while a
// result still waits on the result channel; a finished item waits for that
// register to empty before it moves in.
module decimal_scale_align_top #(
   parameter int MANT_WORDS = 3,
   parameter int MAX_SCALE  = 28
) (
   input  logic  clock,
   input  logic  reset,
   dsa_req_if.sink   req_ch,
   dsa_rsp_if.source rsp_ch
);

   dsa_pkg::dsa_cmd_type    cmd;
   dsa_pkg::dsa_status_type status;
   logic                    req_ready;

   assign req_ch.ready = req_ready;

   dsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dsa_datapath #(
      .MANT_WORDS (MANT_WORDS),
      .MAX_SCALE  (MAX_SCALE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .a_mant_low  (req_ch.a_mant_low),
      .a_mant_high (req_ch.a_mant_high),
      .a_scale     (req_ch.a_scale),
      .b_mant_low  (req_ch.b_mant_low),
      .b_mant_high (req_ch.b_mant_high),
      .b_scale     (req_ch.b_scale),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .a_out_low   (rsp_ch.a_out_low),
      .a_out_high  (rsp_ch.a_out_high),
      .a_out_scale (rsp_ch.a_out_scale),
      .b_out_low   (rsp_ch.b_out_low),
      .b_out_high  (rsp_ch.b_out_high),
      .b_out_scale (rsp_ch.b_out_scale),
      .overflow    (rsp_ch.overflow)
   );

endmodule

/* tb/decimal_scale_align_top_test.sv */
// ----------------------------------------------------------------------------
// decimal_scale_align_top_test
// Self-checking bench for the decimal scale alignment block. A queue of
// operand pairs (a directed set, then random pairs) feeds a clocked driver;
// each accepted pair is aligned by a local times-ten model and the expected
// result is queued. A clocked monitor compares every result field by field.
// Both channels idle at random, and the receiver holds off once for a long
// stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module decimal_scale_align_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FULL_W        = dsa_pkg::FULL_W;
   localparam int SCALE_W       = dsa_pkg::SCALE_W;
   localparam int MANT_LOW_W    = dsa_pkg::MANT_LOW_W;
   localparam int MAX_SCALE     = 28;
   localparam int RANDOM_PAIRS  = 1700;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 600;
   localparam int DRAIN_CYCLES  = 2 * (MAX_SCALE + 2);

   typedef struct packed {
      logic [FULL_W-1:0]  a_mant;
      logic [SCALE_W-1:0] a_scale;
      logic [FULL_W-1:0]  b_mant;
      logic [SCALE_W-1:0] b_scale;
   } operand_pair_type;

   typedef struct packed {
      logic [FULL_W-1:0]  a_mant;
      logic [SCALE_W-1:0] a_scale;
      logic [FULL_W-1:0]  b_mant;
      logic [SCALE_W-1:0] b_scale;
      logic               overflow;
   } aligned_pair_type;

   logic clock;
   logic reset;

   dsa_req_if req_if ();
   dsa_rsp_if rsp_if ();

   decimal_scale_align_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   operand_pair_type pending_pairs[$];
   aligned_pair_type aligned_expect[$];
   operand_pair_type offered;

   int error_count    = 0;
   int pairs_issued   = 0;
   int pairs_accepted = 0;
   int results_seen   = 0;
   int overflow_seen  = 0;
   int capped_seen    = 0;
   int idle_left      = 0;
   int stall_left     = 0;
   int hold_left      = 0;
   bit hold_done      = 0;
   int cycle_count    = 0;

   // Multiply m by ten until s reaches target or the scale cap; stop on carry-out.
   function automatic void raise_scale(inout logic [FULL_W-1:0] m,
                                       inout logic [SCALE_W-1:0] s,
                                       input logic [SCALE_W-1:0] target,
                                       output logic ovf);
      logic [FULL_W+3:0] prod;
      ovf = 1'b0;
      while (s < target && s < MAX_SCALE) begin
         prod = {4'b0, m} * 100'd10;
         m = prod[FULL_W-1:0];
         if (prod[FULL_W+3:FULL_W] != 4'b0) begin
            ovf = 1'b1;
            return;
         end
         s = s + 8'd1;
      end
   endfunction

   function automatic aligned_pair_type align_pair(operand_pair_type p);
      aligned_pair_type r;
      logic ovf;
      r.a_mant  = p.a_mant;
      r.a_scale = p.a_scale;
      r.b_mant  = p.b_mant;
      r.b_scale = p.b_scale;
      ovf = 1'b0;
      if (p.a_scale < p.b_scale)
         raise_scale(r.a_mant, r.a_scale, p.b_scale, ovf);
      else if (p.b_scale < p.a_scale)
         raise_scale(r.b_mant, r.b_scale, p.a_scale, ovf);
      r.overflow = ovf;
      return r;
   endfunction

   // Mostly short gaps, a few long ones, and stretches with none at all.
   function automatic int pick_gap(int idx);
      int r;
      r = $urandom_range(0, 99);
      if ((idx / 150) % 4 == 3)
         return 0;
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [FULL_W-1:0] rand_mant();
      logic [FULL_W-1:0] full;
      int r;
      full = {$urandom, $urandom, $urandom};
      r = $urandom_range(0, 19);
      if (r == 0)
         return '1;
      if (r == 1)
         return '0;
      if (r < 8)
         return full;
      return full >> $urandom_range(1, 95);
   endfunction

   function automatic void compare_field(string name, logic [FULL_W-1:0] want,
                                         logic [FULL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic add_pair(logic [FULL_W-1:0] am, logic [SCALE_W-1:0] as,
                           logic [FULL_W-1:0] bm, logic [SCALE_W-1:0] bs);
      operand_pair_type p;
      p.a_mant  = am;
      p.a_scale = as;
      p.b_mant  = bm;
      p.b_scale = bs;
      pending_pairs.push_back(p);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.a_mant_low  = '0;
      req_if.a_mant_high = '0;
      req_if.a_scale     = '0;
      req_if.b_mant_low  = '0;
      req_if.b_mant_high = '0;
      req_if.b_scale     = '0;
      rsp_if.ready       = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("decimal_scale_align_top regression: fail");
         $finish;
      end
   end

   // Driver: queue the expectation on acceptance, then offer the next item.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            aligned_expect.push_back(align_pair(offered));
            pairs_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (idle_left > 0) begin
               req_if.valid <= 1'b0;
               idle_left--;
            end else if (pending_pairs.size() > 0) begin
               offered = pending_pairs.pop_front();
               req_if.a_mant_low  <= offered.a_mant[MANT_LOW_W-1:0];
               req_if.a_mant_high <= offered.a_mant[FULL_W-1:MANT_LOW_W];
               req_if.a_scale     <= offered.a_scale;
               req_if.b_mant_low  <= offered.b_mant[MANT_LOW_W-1:0];
               req_if.b_mant_high <= offered.b_mant[FULL_W-1:MANT_LOW_W];
               req_if.b_scale     <= offered.b_scale;
               req_if.valid       <= 1'b1;
               idle_left = pick_gap(pairs_issued);
               pairs_issued++;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold: count it down cycle by cycle once enough items went by.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Monitor: check each item against the oldest expectation, then pick ready.
   always @(posedge clock) begin : result_monitor
      aligned_pair_type got;
      aligned_pair_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.a_mant   = {rsp_if.a_out_high, rsp_if.a_out_low};
            got.a_scale  = rsp_if.a_out_scale;
            got.b_mant   = {rsp_if.b_out_high, rsp_if.b_out_low};
            got.b_scale  = rsp_if.b_out_scale;
            got.overflow = rsp_if.overflow;
            if (aligned_expect.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual %h", $time, got);
               error_count++;
            end else begin
               want = aligned_expect.pop_front();
               compare_field("a mantissa", want.a_mant, got.a_mant);
               compare_field("a scale", FULL_W'(want.a_scale), FULL_W'(got.a_scale));
               compare_field("b mantissa", want.b_mant, got.b_mant);
               compare_field("b scale", FULL_W'(want.b_scale), FULL_W'(got.b_scale));
               compare_field("overflow", FULL_W'(want.overflow), FULL_W'(got.overflow));
               if (want.overflow)
                  overflow_seen++;
               if (want.a_scale != want.b_scale && !want.overflow)
                  capped_seen++;
            end
            results_seen++;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
               stall_left = pick_gap(results_seen);
         end
      end
   end

   initial begin
      logic [FULL_W-1:0]  tenth_max;
      logic [FULL_W-1:0]  ones;
      logic [SCALE_W-1:0] sa;
      logic [SCALE_W-1:0] sb;
      int r;
      ones      = '1;
      tenth_max = ones / 96'd10;

      // Directed: edges of mantissa and scale, overflow boundaries, cap cases.
      add_pair('0, 8'd0, '0, 8'd0);
      add_pair(ones, 8'd28, ones, 8'd28);
      add_pair(ones, 8'd0, 96'd7, 8'd1);
      add_pair(tenth_max, 8'd0, ones, 8'd1);
      add_pair(tenth_max + 96'd1, 8'd0, ones, 8'd1);
      add_pair(96'd1, 8'd0, 96'd3, 8'd28);
      add_pair(96'd1, 8'd0, ones, 8'd255);
      add_pair(ones, 8'd255, 96'd1, 8'd0);
      add_pair(96'd5, 8'd28, 96'd9, 8'd255);
      add_pair(96'd11, 8'd40, 96'd22, 8'd30);
      add_pair(ones, 8'd255, '0, 8'd255);
      add_pair(96'd8, 8'd0, 96'd1, 8'd28);
      add_pair(96'd12345, 8'd3, 96'd678, 8'd5);
      add_pair({48{2'b01}}, 8'd7, {48{2'b10}}, 8'd9);
      add_pair({48{2'b10}}, 8'd4, {48{2'b01}}, 8'd2);
      add_pair({32'h1, 64'h0}, 8'd0, 96'd1, 8'd9);
      add_pair({32'h1, 64'h0}, 8'd0, 96'd1, 8'd10);
      add_pair({32'h0, {64{1'b1}}}, 8'd10, 96'd2, 8'd5);
      add_pair(96'd99, 8'd27, 96'd1, 8'd28);
      add_pair('0, 8'd0, 96'd4, 8'd200);

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            sa = 8'($urandom_range(0, 30));
            sb = 8'(sa + $urandom_range(0, 8) - $urandom_range(0, 8));
            if (sb > 8'd30)
               sb = 8'($urandom_range(0, 30));
         end else if (r < 75) begin
            sa = 8'($urandom_range(0, 255));
            sb = sa;
         end else if (r < 85) begin
            sa = 8'($urandom_range(0, 3));
            sb = 8'($urandom_range(26, 31));
         end else begin
            sa = 8'($urandom_range(0, 255));
            sb = 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 1))
            add_pair(rand_mant(), sa, rand_mant(), sb);
         else
            add_pair(rand_mant(), sb, rand_mant(), sa);
      end
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending_pairs.size() > 0 || req_if.valid || aligned_expect.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d operand pairs accepted, %0d aligned results checked", pairs_accepted,
               results_seen);
      $display("%0d results stopped at the scale cap, %0d ended in overflow", capped_seen,
               overflow_seen);
      if (error_count == 0 && aligned_expect.size() == 0)
         $display("decimal_scale_align_top regression: pass");
      else
         $display("decimal_scale_align_top regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_req_if.sv
hw/rtl/dsa_rsp_if.sv
hw/rtl/dsa_ctrl.sv
hw/rtl/dsa_datapath.sv
hw/rtl/decimal_scale_align_top.sv
tb/decimal_scale_align_top_test.sv
